// File: src/assert_macros.svh
// Assertion macros shared by the compositor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LAPC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define LAPC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define LAPC_ASSERT(name, prop, msg)
`define LAPC_ASSERT_IMP(name, ante, cons, msg)
`endif
`endif

// File: src/lapc_pkg.sv
// Types, register codes and constants of the layered alpha pixel compositor.
package lapc_pkg;

  localparam int unsigned STORE_DEPTH = 256;
  localparam int unsigned STORE_AW    = 8;
  localparam int unsigned STORE_W     = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned NUM_W       = 25;

  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_EN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_COL = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ROW = 3'd7;

  localparam logic FUNC_WRITE   = 1'b0;
  localparam logic FUNC_REFRESH = 1'b1;

  localparam logic [1:0] ORDER_GRB = 2'd0;
  localparam logic [1:0] ORDER_RGB = 2'd1;
  localparam logic [1:0] ORDER_BGR = 2'd2;

  typedef logic [24:0] num_t;
  typedef logic [25:0] rcp_t;
  typedef logic [50:0] prod_t;
  typedef logic [40:0] rem_t;

  typedef struct packed {
    logic              func;
    logic [2:0]        layer_sel;
    logic signed [7:0] pos_x;
    logic signed [7:0] pos_y;
    logic [7:0]        alpha_in;
    logic [7:0]        red_in;
    logic [7:0]        green_in;
    logic [7:0]        blue_in;
  } in_req_t;

  typedef struct packed {
    logic [5:0] led_index;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
    logic       last_flag;
  } out_item_t;

  function automatic logic [7:0] clamp_chan(logic [7:0] v, logic [7:0] lim);
    return (v > lim) ? lim : v;
  endfunction

endpackage

// File: src/lapc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lapc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/layered_alpha_pixel_compositor.sv
// Layered alpha pixel compositor: top level with store, blend sequencer and output register.
// A write request with an in-range layer and position stores one clamped pixel and yields
// one result; a refresh request yields COLUMNS*ROWS results in LED order, the last one
// flagged. Each result passes a start state for its position, then per layer the blend
// loop (multiply, scale and sum, reciprocal multiply, remainder correction), with the store
// read for the next layer overlapping the correction step, then an emit state that loads the
// output register. A dead pixel goes from the start state straight to the emit state. A new
// request is accepted once the last result of the previous one sits in the output register.
// The store is cleared at reset through per-entry valid bits, so no clearing pass is needed.
`include "assert_macros.svh"

module layered_alpha_pixel_compositor #(
  parameter int unsigned LAYERS     = 4,
  parameter int unsigned COLUMNS    = 8,
  parameter int unsigned ROWS       = 8,
  parameter int unsigned COLOR_MAX  = 255,
  parameter int unsigned BRIGHT_MAX = 255
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  lapc_pkg::in_req_t                in_req_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output lapc_pkg::out_item_t              out_rsp_o,
  input  logic                             cfg_we_i,
  input  logic [lapc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lapc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_START = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_SUM   = 7'b0001000,
    ST_RCP   = 7'b0010000,
    ST_FIX   = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_e;

  localparam logic [7:0]  CM8   = 8'(COLOR_MAX);
  localparam logic [7:0]  BM8   = 8'(BRIGHT_MAX);
  localparam logic [15:0] DIV_K = 16'(COLOR_MAX * BRIGHT_MAX);
  localparam lapc_pkg::rcp_t RECIP =
    lapc_pkg::rcp_t'((64'd1 << lapc_pkg::NUM_W) / (COLOR_MAX * BRIGHT_MAX));

  state_e state_q, state_d;
  logic       refresh_q, refresh_d;
  logic [2:0] col_q, col_d;
  logic [2:0] row_q, row_d;
  logic [2:0] layer_q, layer_d;

  logic [7:0] bright_q [4];
  logic [1:0] order_q;
  logic       dead_en_q;
  logic [2:0] dead_col_q;
  logic [2:0] dead_row_q;

  logic [lapc_pkg::STORE_DEPTH-1:0] entry_vld_q;
  logic                             rd_vld_q;
  logic                             ram_we;
  logic [lapc_pkg::STORE_AW-1:0]    ram_waddr;
  logic [lapc_pkg::STORE_W-1:0]     ram_wdata;
  logic [lapc_pkg::STORE_AW-1:0]    ram_raddr;
  logic [lapc_pkg::STORE_W-1:0]     ram_rdata;
  logic [2:0]                       rd_layer;

  logic                   accept;
  logic                   wr_ok;
  logic                   dead_hit;
  logic                   last_pos;
  logic                   out_load;
  logic                   out_valid_q, out_valid_d;
  lapc_pkg::out_item_t    out_rsp_q, out_rsp_d;

  logic [lapc_pkg::STORE_W-1:0] src;
  logic [7:0]                   alpha;
  logic [7:0]                   br;
  logic [7:0]                   src_chan [3];
  logic [15:0]                  m1_q [3], m1_d [3];
  logic [15:0]                  as_q [3], as_d [3];
  lapc_pkg::num_t               num_q [3], num_d [3];
  lapc_pkg::num_t               qe_q [3], qe_d [3];
  lapc_pkg::rem_t               rem [3];
  lapc_pkg::num_t               qfix [3];
  logic [7:0]                   acc_q [3], acc_d [3];
  logic [7:0]                   b1, b2, b3;

  // Request acceptance and store write
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign wr_ok      = !in_req_i.func
                   && (4'(in_req_i.layer_sel) < 4'(LAYERS))
                   && !in_req_i.pos_x[7] && ($unsigned(in_req_i.pos_x) < 8'(COLUMNS))
                   && !in_req_i.pos_y[7] && ($unsigned(in_req_i.pos_y) < 8'(ROWS));
  assign ram_we     = accept && wr_ok;
  assign ram_waddr  = {in_req_i.layer_sel[1:0], in_req_i.pos_y[2:0], in_req_i.pos_x[2:0]};
  assign ram_wdata  = {lapc_pkg::clamp_chan(in_req_i.alpha_in, CM8),
                       lapc_pkg::clamp_chan(in_req_i.red_in, CM8),
                       lapc_pkg::clamp_chan(in_req_i.green_in, CM8),
                       lapc_pkg::clamp_chan(in_req_i.blue_in, CM8)};

  // Fetch layer zero at start, the next layer during correction
  assign rd_layer  = (state_q == ST_START) ? 3'd0 : 3'(layer_q + 3'd1);
  assign ram_raddr = {rd_layer[1:0], row_q, col_q};

  lapc_ram #(
    .WIDTH(lapc_pkg::STORE_W),
    .DEPTH(lapc_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_vld_q <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      if (ram_we) begin
        entry_vld_q[ram_waddr] <= 1'b1;
      end
      rd_vld_q <= entry_vld_q[ram_raddr];
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        bright_q[i] <= 8'hFF;
      end
      order_q    <= lapc_pkg::ORDER_GRB;
      dead_en_q  <= 1'b1;
      dead_col_q <= 3'd2;
      dead_row_q <= 3'd6;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lapc_pkg::REG_BRIGHT0:  bright_q[0] <= cfg_data_i;
        lapc_pkg::REG_BRIGHT1:  bright_q[1] <= cfg_data_i;
        lapc_pkg::REG_BRIGHT2:  bright_q[2] <= cfg_data_i;
        lapc_pkg::REG_BRIGHT3:  bright_q[3] <= cfg_data_i;
        lapc_pkg::REG_ORDER:    order_q     <= cfg_data_i[1:0];
        lapc_pkg::REG_DEAD_EN:  dead_en_q   <= cfg_data_i[0];
        lapc_pkg::REG_DEAD_COL: dead_col_q  <= cfg_data_i[2:0];
        lapc_pkg::REG_DEAD_ROW: dead_row_q  <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign dead_hit = dead_en_q && (col_q == dead_col_q) && (row_q == dead_row_q);
  assign last_pos = !refresh_q
                 || ((col_q == 3'(COLUMNS - 1)) && (row_q == 3'(ROWS - 1)));
  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    refresh_d = refresh_q;
    col_d     = col_q;
    row_d     = row_q;
    layer_d   = layer_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_req_i.func) begin
          refresh_d = 1'b1;
          col_d     = 3'd0;
          row_d     = 3'd0;
          state_d   = ST_START;
        end else if (ram_we) begin
          refresh_d = 1'b0;
          col_d     = in_req_i.pos_x[2:0];
          row_d     = in_req_i.pos_y[2:0];
          state_d   = ST_START;
        end
      end
      ST_START: begin
        layer_d = 3'd0;
        state_d = dead_hit ? ST_EMIT : ST_MUL;
      end
      ST_MUL: state_d = ST_SUM;
      ST_SUM: state_d = ST_RCP;
      ST_RCP: state_d = ST_FIX;
      ST_FIX: begin
        if (layer_q == 3'(LAYERS - 1)) begin
          state_d = ST_EMIT;
        end else begin
          layer_d = 3'(layer_q + 3'd1);
          state_d = ST_MUL;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          if (last_pos) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_START;
            if (col_q == 3'(COLUMNS - 1)) begin
              col_d = 3'd0;
              row_d = 3'(row_q + 3'd1);
            end else begin
              col_d = 3'(col_q + 3'd1);
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      refresh_q   <= 1'b0;
      col_q       <= 3'd0;
      row_q       <= 3'd0;
      layer_q     <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      refresh_q   <= refresh_d;
      col_q       <= col_d;
      row_q       <= row_d;
      layer_q     <= layer_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Blend datapath, one lane per color channel
  assign src   = rd_vld_q ? ram_rdata : '0;
  assign alpha = src[31:24];
  assign br    = layer_q[2] ? BM8 : bright_q[layer_q[1:0]];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      src_chan[c] = src[8*(2-c) +: 8];
      m1_d[c]  = m1_q[c];
      as_d[c]  = as_q[c];
      num_d[c] = num_q[c];
      qe_d[c]  = qe_q[c];
      acc_d[c] = acc_q[c];
      rem[c]   = lapc_pkg::rem_t'(num_q[c])
               - lapc_pkg::rem_t'(qe_q[c]) * lapc_pkg::rem_t'(DIV_K);
      qfix[c]  = qe_q[c] + lapc_pkg::num_t'(rem[c] >= lapc_pkg::rem_t'(DIV_K));
      if (state_q == ST_MUL) begin
        m1_d[c] = 16'(CM8 - alpha) * 16'(acc_q[c]);
        as_d[c] = 16'(alpha) * 16'(src_chan[c]);
      end
      if (state_q == ST_SUM) begin
        num_d[c] = lapc_pkg::num_t'(m1_q[c]) * lapc_pkg::num_t'(BM8)
                 + lapc_pkg::num_t'(as_q[c]) * lapc_pkg::num_t'(br);
      end
      if (state_q == ST_RCP) begin
        qe_d[c] = lapc_pkg::num_t'((lapc_pkg::prod_t'(num_q[c])
                * lapc_pkg::prod_t'(RECIP)) >> lapc_pkg::NUM_W);
      end
      if (state_q == ST_START) begin
        acc_d[c] = 8'd0;
      end else if (state_q == ST_FIX) begin
        acc_d[c] = (qfix[c] > lapc_pkg::num_t'(CM8)) ? CM8 : qfix[c][7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      m1_q[c]  <= m1_d[c];
      as_q[c]  <= as_d[c];
      num_q[c] <= num_d[c];
      qe_q[c]  <= qe_d[c];
      acc_q[c] <= acc_d[c];
    end
    out_rsp_q <= out_rsp_d;
  end

  // Output register
  always_comb begin
    case (order_q)
      lapc_pkg::ORDER_GRB: begin
        b1 = acc_q[1];
        b2 = acc_q[0];
        b3 = acc_q[2];
      end
      lapc_pkg::ORDER_RGB: begin
        b1 = acc_q[0];
        b2 = acc_q[1];
        b3 = acc_q[2];
      end
      default: begin
        b1 = acc_q[2];
        b2 = acc_q[1];
        b3 = acc_q[0];
      end
    endcase
  end

  always_comb begin
    out_rsp_d   = out_rsp_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d           = 1'b1;
      out_rsp_d.led_index   = 6'(col_q) + 6'(row_q) * 6'(COLUMNS);
      out_rsp_d.first_byte  = b1;
      out_rsp_d.second_byte = b2;
      out_rsp_d.third_byte  = b3;
      out_rsp_d.last_flag   = last_pos;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  `LAPC_ASSERT_IMP(a_store_wr_on_accept, ram_we, accept && !in_req_i.func, "store write without accepted write request")
  `LAPC_ASSERT(a_refresh_starts, (accept && in_req_i.func) |=> (state_q == ST_START && refresh_q), "refresh request did not start compositing")
  `LAPC_ASSERT(a_more_after_partial, (out_load && !last_pos) |=> (state_q == ST_START), "refresh stopped before the last position")
  `LAPC_ASSERT_IMP(a_layer_bound, state_q != ST_IDLE, 4'(layer_q) < 4'(LAYERS), "layer counter beyond layer count")

endmodule

// File: verif/lapc_checker.sv
// Checker for the layered alpha pixel compositor: predicts composited LED results and compares.
module lapc_checker #(
  parameter int unsigned LAYERS     = 4,
  parameter int unsigned COLUMNS    = 8,
  parameter int unsigned ROWS       = 8,
  parameter int unsigned COLOR_MAX  = 255,
  parameter int unsigned BRIGHT_MAX = 255
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  lapc_pkg::in_req_t               in_req_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  lapc_pkg::out_item_t             out_rsp_i,
  input  logic                            cfg_we_i,
  input  logic [lapc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lapc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0]         layer_store [lapc_pkg::STORE_DEPTH];
  logic [7:0]          brightness [4];
  logic [1:0]          color_order;
  logic                dead_en;
  logic [2:0]          dead_col;
  logic [2:0]          dead_row;
  lapc_pkg::out_item_t expected_leds [$];

  function automatic longint unsigned sat_chan(longint unsigned v);
    return (v > COLOR_MAX) ? longint'(COLOR_MAX) : v;
  endfunction

  function automatic longint unsigned over_blend(longint unsigned d, longint unsigned a,
                                                 longint unsigned s, longint unsigned br);
    longint unsigned num;
    num = (longint'(COLOR_MAX) - a) * d * BRIGHT_MAX + a * s * br;
    return sat_chan(num / (longint'(COLOR_MAX) * BRIGHT_MAX));
  endfunction

  function automatic lapc_pkg::out_item_t composite_led(int col, int row, logic last);
    longint unsigned     r, g, b, a, br;
    logic [31:0]         e;
    lapc_pkg::out_item_t o;
    int                  l;
    r = 0;
    g = 0;
    b = 0;
    if (!(dead_en && col == int'(dead_col) && row == int'(dead_row))) begin
      for (l = 0; l < LAYERS; l++) begin
        e  = layer_store[(l * 64 + row * 8 + col) % lapc_pkg::STORE_DEPTH];
        a  = e[31:24];
        br = (l < 4) ? longint'(brightness[l % 4]) : longint'(BRIGHT_MAX);
        r  = over_blend(r, a, e[23:16], br);
        g  = over_blend(g, a, e[15:8], br);
        b  = over_blend(b, a, e[7:0], br);
      end
    end
    o.led_index = 6'(col + row * COLUMNS);
    o.last_flag = last;
    case (color_order)
      lapc_pkg::ORDER_GRB: begin
        o.first_byte  = g[7:0];
        o.second_byte = r[7:0];
        o.third_byte  = b[7:0];
      end
      lapc_pkg::ORDER_RGB: begin
        o.first_byte  = r[7:0];
        o.second_byte = g[7:0];
        o.third_byte  = b[7:0];
      end
      default: begin
        o.first_byte  = b[7:0];
        o.second_byte = g[7:0];
        o.third_byte  = r[7:0];
      end
    endcase
    return o;
  endfunction

  function automatic void predict_request(lapc_pkg::in_req_t req);
    int x, y, col, row;
    x = $signed(req.pos_x);
    y = $signed(req.pos_y);
    if (req.func == lapc_pkg::FUNC_REFRESH) begin
      for (row = 0; row < ROWS; row++) begin
        for (col = 0; col < COLUMNS; col++) begin
          expected_leds.push_back(composite_led(col, row,
                                                row == ROWS - 1 && col == COLUMNS - 1));
        end
      end
    end else if (req.layer_sel < LAYERS && x >= 0 && x < COLUMNS && y >= 0 && y < ROWS) begin
      layer_store[(req.layer_sel * 64 + y * 8 + x) % lapc_pkg::STORE_DEPTH] =
        {8'(sat_chan(req.alpha_in)), 8'(sat_chan(req.red_in)),
         8'(sat_chan(req.green_in)), 8'(sat_chan(req.blue_in))};
      expected_leds.push_back(composite_led(x, y, 1'b1));
    end
  endfunction

  function automatic void log_mismatch(string why, lapc_pkg::out_item_t want,
                                       lapc_pkg::out_item_t got);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("%0t mismatch (%s): expected led %0d bytes %02h %02h %02h last %0b,",
               $realtime, why, want.led_index, want.first_byte, want.second_byte,
               want.third_byte, want.last_flag);
      $display("    actual led %0d bytes %02h %02h %02h last %0b", got.led_index,
               got.first_byte, got.second_byte, got.third_byte, got.last_flag);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lapc_pkg::out_item_t want;
    if (!rst_ni) begin
      foreach (layer_store[i]) layer_store[i] = '0;
      foreach (brightness[i]) brightness[i] = 8'd255;
      color_order = lapc_pkg::ORDER_GRB;
      dead_en     = 1'b1;
      dead_col    = 3'd2;
      dead_row    = 3'd6;
      expected_leds.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          lapc_pkg::REG_BRIGHT0:  brightness[0] = cfg_data_i;
          lapc_pkg::REG_BRIGHT1:  brightness[1] = cfg_data_i;
          lapc_pkg::REG_BRIGHT2:  brightness[2] = cfg_data_i;
          lapc_pkg::REG_BRIGHT3:  brightness[3] = cfg_data_i;
          lapc_pkg::REG_ORDER:    color_order   = cfg_data_i[1:0];
          lapc_pkg::REG_DEAD_EN:  dead_en       = cfg_data_i[0];
          lapc_pkg::REG_DEAD_COL: dead_col      = cfg_data_i[2:0];
          lapc_pkg::REG_DEAD_ROW: dead_row      = cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_leds.size() == 0) begin
          log_mismatch("unexpected result", '0, out_rsp_i);
        end else begin
          want = expected_leds.pop_front();
          if (want.led_index !== out_rsp_i.led_index ||
              want.first_byte !== out_rsp_i.first_byte ||
              want.second_byte !== out_rsp_i.second_byte ||
              want.third_byte !== out_rsp_i.third_byte ||
              want.last_flag !== out_rsp_i.last_flag) begin
            log_mismatch("field", want, out_rsp_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_request(in_req_i);
      end
      pending_o = expected_leds.size();
    end
  end

endmodule

// File: verif/tb_top.sv
// Testbench top for the layered alpha pixel compositor: clock, reset, stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LAYERS     = 4;
  localparam int unsigned COLUMNS    = 8;
  localparam int unsigned ROWS       = 8;
  localparam int unsigned COLOR_MAX  = 255;
  localparam int unsigned BRIGHT_MAX = 255;

  localparam logic [1:0] ORDER_BGR_ALT = 2'd3;
  localparam int         SETTLE_CYCLES = 40;

  logic                            clk_i;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_stall_o;
  lapc_pkg::in_req_t               in_req_i    = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  lapc_pkg::out_item_t             out_rsp_o;
  logic                            cfg_we_i    = 1'b0;
  logic [lapc_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [lapc_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;
  int                              fail_count;
  int                              pending;
  bit                              idle_en     = 1'b1;
  int                              stall_left  = 0;

  layered_alpha_pixel_compositor #(
    .LAYERS    (LAYERS),
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .COLOR_MAX (COLOR_MAX),
    .BRIGHT_MAX(BRIGHT_MAX)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  lapc_checker #(
    .LAYERS    (LAYERS),
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .COLOR_MAX (COLOR_MAX),
    .BRIGHT_MAX(BRIGHT_MAX)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_i   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 7);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic lapc_pkg::in_req_t pixel_req(logic [2:0] layer, int x, int y,
                                                  logic [7:0] a, logic [7:0] r,
                                                  logic [7:0] g, logic [7:0] b);
    lapc_pkg::in_req_t q;
    q.func      = lapc_pkg::FUNC_WRITE;
    q.layer_sel = layer;
    q.pos_x     = 8'(x);
    q.pos_y     = 8'(y);
    q.alpha_in  = a;
    q.red_in    = r;
    q.green_in  = g;
    q.blue_in   = b;
    return q;
  endfunction

  function automatic logic [7:0] pick_chan();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic lapc_pkg::in_req_t random_req();
    lapc_pkg::in_req_t q;
    int                sel;
    sel = $urandom_range(0, 99);
    q = pixel_req(3'($urandom_range(0, LAYERS - 1)), $urandom_range(0, COLUMNS - 1),
                  $urandom_range(0, ROWS - 1), pick_chan(), pick_chan(), pick_chan(),
                  pick_chan());
    if (sel < 8) begin
      q.func = lapc_pkg::FUNC_REFRESH;
    end else if (sel < 20) begin
      q.layer_sel = 3'($urandom_range(0, 7));
      q.pos_x     = 8'($urandom);
      q.pos_y     = 8'($urandom);
    end
    return q;
  endfunction

  task automatic push_request(lapc_pkg::in_req_t q);
    int gap;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= q;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic refresh_all();
    lapc_pkg::in_req_t q;
    q      = random_req();
    q.func = lapc_pkg::FUNC_REFRESH;
    push_request(q);
  endtask

  task automatic run_random(int count);
    lapc_pkg::in_req_t q;
    for (int i = 0; i < count; i++) begin
      q = random_req();
      push_request(q);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [lapc_pkg::CFG_IDX_W-1:0] idx,
                           logic [lapc_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_dead(logic en, logic [2:0] col, logic [2:0] row);
    cfg_write(lapc_pkg::REG_DEAD_EN, lapc_pkg::CFG_DATA_W'(en));
    cfg_write(lapc_pkg::REG_DEAD_COL, lapc_pkg::CFG_DATA_W'(col));
    cfg_write(lapc_pkg::REG_DEAD_ROW, lapc_pkg::CFG_DATA_W'(row));
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    push_request(pixel_req(3'd0, 0, 0, 8'hFF, 8'hFF, 8'h00, 8'h80));
    push_request(pixel_req(3'd1, 0, 0, 8'h80, 8'h10, 8'hFF, 8'h40));
    push_request(pixel_req(3'd2, 0, 0, 8'h00, 8'hFF, 8'hFF, 8'hFF));
    push_request(pixel_req(3'd3, 0, 0, 8'h01, 8'hFF, 8'hFF, 8'hFF));
    push_request(pixel_req(3'd3, 7, 7, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    push_request(pixel_req(3'd0, 2, 6, 8'hFF, 8'hC8, 8'hC8, 8'hC8));
    push_request(pixel_req(3'd0, 7, 0, 8'hFF, 8'h00, 8'h7F, 8'hFF));
    push_request(pixel_req(3'd0, 0, 7, 8'hAA, 8'h55, 8'hAA, 8'h55));
    push_request(pixel_req(3'd4, 1, 1, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    push_request(pixel_req(3'd7, 1, 1, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    push_request(pixel_req(3'd0, -1, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    push_request(pixel_req(3'd0, 8, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    push_request(pixel_req(3'd0, 0, -128, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    push_request(pixel_req(3'd0, 127, 127, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    push_request(pixel_req(3'd0, -128, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    refresh_all();
    push_request(pixel_req(3'd1, 7, 7, 8'hFF, 8'h00, 8'h00, 8'h00));
    push_request(pixel_req(3'd2, 3, 4, 8'h7F, 8'hFF, 8'h00, 8'hFF));
    refresh_all();
    run_random(80);
    drain();

    cfg_write(lapc_pkg::REG_BRIGHT0, 8'd0);
    cfg_write(lapc_pkg::REG_BRIGHT1, 8'd255);
    cfg_write(lapc_pkg::REG_BRIGHT2, 8'd1);
    cfg_write(lapc_pkg::REG_BRIGHT3, 8'd128);
    cfg_write(lapc_pkg::REG_ORDER, lapc_pkg::CFG_DATA_W'(lapc_pkg::ORDER_RGB));
    set_dead(1'b0, 3'd7, 3'd0);
    refresh_all();
    run_random(80);
    drain();

    cfg_write(lapc_pkg::REG_BRIGHT0, 8'($urandom));
    cfg_write(lapc_pkg::REG_BRIGHT1, 8'($urandom));
    cfg_write(lapc_pkg::REG_BRIGHT2, 8'($urandom));
    cfg_write(lapc_pkg::REG_BRIGHT3, 8'($urandom));
    cfg_write(lapc_pkg::REG_ORDER, lapc_pkg::CFG_DATA_W'(lapc_pkg::ORDER_BGR));
    set_dead(1'b1, 3'd7, 3'd7);
    push_request(pixel_req(3'd0, 7, 7, 8'hFF, 8'h12, 8'h34, 8'h56));
    refresh_all();
    run_random(80);
    drain();

    cfg_write(lapc_pkg::REG_BRIGHT0, 8'd255);
    cfg_write(lapc_pkg::REG_BRIGHT1, 8'd255);
    cfg_write(lapc_pkg::REG_BRIGHT2, 8'd255);
    cfg_write(lapc_pkg::REG_BRIGHT3, 8'd0);
    cfg_write(lapc_pkg::REG_ORDER, lapc_pkg::CFG_DATA_W'(ORDER_BGR_ALT));
    set_dead(1'b1, 3'd0, 3'd0);
    refresh_all();
    run_random(80);
    drain();

    idle_en = 1'b0;
    cfg_write(lapc_pkg::REG_BRIGHT0, 8'($urandom));
    cfg_write(lapc_pkg::REG_BRIGHT1, 8'($urandom));
    cfg_write(lapc_pkg::REG_BRIGHT2, 8'($urandom));
    cfg_write(lapc_pkg::REG_BRIGHT3, 8'($urandom));
    cfg_write(lapc_pkg::REG_ORDER, lapc_pkg::CFG_DATA_W'(lapc_pkg::ORDER_GRB));
    set_dead(1'b1, 3'd2, 3'd6);
    run_random(70);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
